// ===== hdl/base64_stream_encoder_assert.svh =====
// Assertion macros for the base64 stream encoder.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define B64SE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that holds in reset as well.
`define B64SE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/b64se_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 encoder.
`timescale 1ns / 1ps
`default_nettype none

package b64se_pkg;

    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [5:0] GPL_RESET = 6'd19;

    // One run of output characters, built by the front part
    typedef struct packed {
        logic [4:0][7:0] chars;   // chars[0] goes out first
        logic [2:0]      len;     // 1..5
        logic            done;    // run comes from a finish item
    } t_job;

    // Queue status seen by back part and top
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Standard base64 alphabet
    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)      b64_sym = w + 8'd65;
        else if (v < 6'd52) b64_sym = w + 8'd71;
        else if (v < 6'd62) b64_sym = w - 8'd4;
        else if (v == 6'd62) b64_sym = 8'h2B;
        else                b64_sym = 8'h2F;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/b64se_front.sv =====
// Front part: accepts items, holds pending bytes and line position, builds runs.
`timescale 1ns / 1ps
`default_nettype none

module b64se_front import b64se_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_accept,
    input  wire        i_op,
    input  wire  [7:0] i_byte,
    input  wire  [5:0] i_gpl,
    output logic       o_push,
    output t_job       o_job
);

    logic [7:0] r_p0, r_p1, n_p0, n_p1;
    logic [1:0] r_cnt, n_cnt;
    logic [5:0] r_gol, n_gol;

    logic [5:0] gol_inc;
    logic [7:0] b1_fin;
    logic [7:0] s0, s1, s2, s3;
    logic [7:0] f0, f1, f2;

    // Symbols for a full group and for a flushed partial group
    assign gol_inc = r_gol + 6'd1;
    assign b1_fin  = (r_cnt == 2'd2) ? r_p1 : 8'h00;
    assign s0 = b64_sym(r_p0[7:2]);
    assign s1 = b64_sym({r_p0[1:0], r_p1[7:4]});
    assign s2 = b64_sym({r_p1[3:0], i_byte[7:6]});
    assign s3 = b64_sym(i_byte[5:0]);
    assign f0 = s0;
    assign f1 = b64_sym({r_p0[1:0], b1_fin[7:4]});
    assign f2 = (r_cnt == 2'd2) ? b64_sym({b1_fin[3:0], 2'b00}) : CHAR_PAD;

    // Classify the item and work out the next state
    always_comb begin
        n_p0   = r_p0;
        n_p1   = r_p1;
        n_cnt  = r_cnt;
        n_gol  = r_gol;
        o_push = 1'b0;
        o_job  = '0;
        if (i_accept) begin
            if (!i_op) begin
                if (r_cnt != 2'd2) begin
                    if (r_cnt[0]) n_p1 = i_byte;
                    else          n_p0 = i_byte;
                    n_cnt = r_cnt + 2'd1;
                end else begin
                    o_push       = 1'b1;
                    o_job.chars  = {CHAR_NL, s3, s2, s1, s0};
                    n_cnt        = 2'd0;
                    if (gol_inc == i_gpl) begin
                        o_job.len = 3'd5;
                        n_gol     = 6'd0;
                    end else begin
                        o_job.len = 3'd4;
                        n_gol     = gol_inc;
                    end
                end
            end else begin
                o_job.done = 1'b1;
                if (r_cnt != 2'd0) begin
                    o_push      = 1'b1;
                    o_job.chars = {CHAR_NL, CHAR_PAD, f2, f1, f0};
                    o_job.len   = 3'd5;
                end else if (r_gol != 6'd0) begin
                    o_push      = 1'b1;
                    o_job.chars = {32'h0, CHAR_NL};
                    o_job.len   = 3'd1;
                end
                n_cnt = 2'd0;
                n_gol = 6'd0;
            end
        end
    end

    // Pending bytes carry no reset; the count tells which are live
    always_ff @(posedge i_clk) begin
        r_p0 <= n_p0;
        r_p1 <= n_p1;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_gol <= 6'd0;
        end else begin
            r_cnt <= n_cnt;
            r_gol <= n_gol;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/b64se_queue.sv =====
// Two-entry queue of runs between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module b64se_queue import b64se_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  t_job       i_wdata,
    input  wire        i_pop,
    output t_job       o_rdata,
    output t_qstat     o_stat
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_rdata      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_wdata;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/b64se_back.sv =====
// Back part: plays out each run one character per cycle into the output register while the output is ready.
`timescale 1ns / 1ps
`default_nettype none

module b64se_back import b64se_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_job       i_job,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [7:0] o_char,
    output logic       o_last,
    output logic       o_done
);

    t_job       r_job;
    logic [2:0] r_idx;
    logic       r_busy;
    logic       r_ovalid, r_olast, r_odone;
    logic [7:0] r_ochar;

    logic can_load, step, is_last;

    assign can_load = !r_ovalid || i_ready;
    assign step     = r_busy && can_load;
    assign is_last  = (r_idx == (r_job.len - 3'd1));
    assign o_pop    = !i_qstat.empty && (!r_busy || (step && is_last));

    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;
    assign o_done  = r_odone;

    // Current run and character index
    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (step) begin
            r_idx <= r_idx + 3'd1;
            if (is_last) r_busy <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_ochar <= r_job.chars[r_idx];
            r_olast <= is_last;
            r_odone <= r_job.done;
        end
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (can_load) begin
            r_ovalid <= step;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/base64_stream_encoder.sv =====
// A group-completing byte's run is written into the queue, then loaded into the back part's run register,
// and its first character is then registered in the output register.
// Throughput: one output character per cycle from the single output register while the result side is ready.
// A two-run queue lets input items go on while the output side stalls.
// Reset: synchronous active low; clears pending count, line position and queue,
// and sets groups_per_line to 19.
`timescale 1ns / 1ps
`default_nettype none

`include "base64_stream_encoder_assert.svh"

module base64_stream_encoder import b64se_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // input items
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire  [7:0] i_s_tdata,     // [7:0] data_byte
    input  wire  [0:0] i_s_tuser,     // [0] opcode
    // result items
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    output logic [7:0] o_m_tdata,     // [7:0] out_char
    output logic       o_m_tlast,
    output logic [0:0] o_m_tuser,     // [0] message_done
    // groups_per_line write channel
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [5:0] i_cfg_data
);

    logic [5:0] r_gpl;
    logic       s_accept;
    logic       push, pop;
    t_job       wjob, rjob;
    t_qstat     qstat;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !qstat.full;
    assign s_accept    = i_s_tvalid && o_s_tready;

    // Line length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpl <= GPL_RESET;
        end else if (i_cfg_valid) begin
            r_gpl <= i_cfg_data;
        end
    end

    b64se_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_op     (i_s_tuser[0]),
        .i_byte   (i_s_tdata),
        .i_gpl    (r_gpl),
        .o_push   (push),
        .o_job    (wjob)
    );

    b64se_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wjob),
        .i_pop   (pop),
        .o_rdata (rjob),
        .o_stat  (qstat)
    );

    b64se_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (rjob),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_char  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_done  (o_m_tuser[0])
    );

    // A finish run always closes with a newline
    `B64SE_ASSERT(a_finish_ends_nl, o_m_tvalid && o_m_tuser[0] && o_m_tlast |-> o_m_tdata == CHAR_NL, "finish run does not end in newline")
    // Data runs never carry padding
    `B64SE_ASSERT(a_data_no_pad, o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata != CHAR_PAD, "pad character in a data run")
    // Queue cannot be full and empty at once
    `B64SE_ASSERT(a_q_status, !(qstat.full && qstat.empty), "queue full and empty together")
    // Nothing is pushed into a full queue
    `B64SE_ASSERT(a_no_overflow, qstat.full |-> !push, "push into full queue")

endmodule

`default_nettype wire
